[rtl/btad_pkg.sv]
// Shared constants and types for the advertising payload sensor decoder.
`timescale 1ns / 1ps
package btad_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] fmt_t;

  localparam byte_t VENDOR_TYPE = 8'hFF;
  localparam byte_t MARK_A      = 8'h88;
  localparam byte_t MARK_B      = 8'hEC;

  localparam fmt_t FMT_NONE  = 2'd0;
  localparam fmt_t FMT_EIGHT = 2'd1;
  localparam fmt_t FMT_NINE  = 2'd2;

  localparam int unsigned VALUE_W = 19;
  localparam int unsigned QUOT_W  = 10;

  // The quotient by 1000 of any 19-bit value is exact as (v * 536871) >> 29.
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;
  localparam int unsigned RECIP_SHIFT = 29;

endpackage

[rtl/ble_thermo_advert_decoder_core.sv]
// Top level of the advertising payload sensor decoder.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  data_byte, last_byte
//   output   out        out_valid/out_ready  found, format, temperature_centi,
//                                            humidity_centi, battery
//
// A byte is taken when in_valid and in_ready are both high; one can be accepted in every
// cycle. The result of an advertisement is registered on the edge that accepts its last
// byte and is shown from the next cycle on. The output register frees in the cycle it is
// taken, so input stalls only while a result waits and out_ready is low. The divide by
// 1000 is a registered reciprocal multiply fed from the stored field bytes. Reset clears
// the parser and drops any pending result.
`timescale 1ns / 1ps
module ble_thermo_advert_decoder_core
  import btad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [1:0]  format,
  output logic signed [15:0] temperature_centi,
  output logic [15:0] humidity_centi,
  output logic [7:0]  battery
);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]  phase, phase_next;
  byte_t       bytes_left, bytes_left_next;
  byte_t       field_length, field_length_next;
  logic        field_is_vendor, field_is_vendor_next;
  logic        match_found, match_found_next;
  fmt_t        held_format, held_format_next;
  logic [15:0] held_temperature, held_temperature_next;
  logic [15:0] held_humidity, held_humidity_next;
  byte_t       held_battery, held_battery_next;
  byte_t       field_bytes [8];

  logic              in_fire;
  byte_t             idx;
  logic              fb_we;
  logic [VALUE_W-1:0] dec_value;
  logic [QUOT_W-1:0]  dec_quot;
  logic [15:0]       q10;
  logic [15:0]       v10;
  logic [15:0]       q10k;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign idx      = field_length - bytes_left;

  assign dec_value = {field_bytes[3][2:0], field_bytes[4], field_bytes[5]};

  btad_div1000 u_div (
    .clk      (clk),
    .value    (dec_value),
    .quotient (dec_quot)
  );

  assign q10  = {{(16-QUOT_W){1'b0}}, dec_quot} * 16'd10;
  assign q10k = {{(16-QUOT_W){1'b0}}, dec_quot} * 16'd10000;
  assign v10  = dec_value[15:0] * 16'd10;

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    field_length_next     = field_length;
    field_is_vendor_next  = field_is_vendor;
    match_found_next      = match_found;
    held_format_next      = held_format;
    held_temperature_next = held_temperature;
    held_humidity_next    = held_humidity;
    held_battery_next     = held_battery;
    fb_we                 = 1'b0;
    if (!match_found) begin
      unique case (phase)
        PH_LEN: begin
          if (data_byte != 8'd0) begin
            field_length_next = data_byte - 8'd1;
            phase_next        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          field_is_vendor_next = (data_byte == VENDOR_TYPE);
          if (field_length == 8'd0) begin
            phase_next = PH_LEN;
          end else begin
            bytes_left_next = field_length;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          fb_we           = (idx[7:3] == 5'd0);
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_LEN;
            if (field_is_vendor && (field_length == 8'd8 || field_length == 8'd9) &&
                field_bytes[0] == MARK_A && field_bytes[1] == MARK_B) begin
              match_found_next = 1'b1;
              if (field_length == 8'd8) begin
                held_format_next      = FMT_EIGHT;
                held_temperature_next = field_bytes[3][7] ? (16'd0 - q10) : q10;
                held_humidity_next    = v10 - q10k;
                held_battery_next     = field_bytes[6];
              end else begin
                held_format_next      = FMT_NINE;
                held_temperature_next = {field_bytes[4], field_bytes[3]};
                held_humidity_next    = {field_bytes[6], field_bytes[5]};
                held_battery_next     = field_bytes[7];
              end
            end
          end
        end
        default: begin
          phase_next = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN;
      bytes_left       <= 8'd0;
      field_length     <= 8'd0;
      field_is_vendor  <= 1'b0;
      match_found      <= 1'b0;
      held_format      <= FMT_NONE;
      held_temperature <= 16'd0;
      held_humidity    <= 16'd0;
      held_battery     <= 8'd0;
    end else if (in_fire) begin
      if (last_byte) begin
        phase            <= PH_LEN;
        bytes_left       <= 8'd0;
        field_length     <= 8'd0;
        field_is_vendor  <= 1'b0;
        match_found      <= 1'b0;
        held_format      <= FMT_NONE;
        held_temperature <= 16'd0;
        held_humidity    <= 16'd0;
        held_battery     <= 8'd0;
      end else begin
        phase            <= phase_next;
        bytes_left       <= bytes_left_next;
        field_length     <= field_length_next;
        field_is_vendor  <= field_is_vendor_next;
        match_found      <= match_found_next;
        held_format      <= held_format_next;
        held_temperature <= held_temperature_next;
        held_humidity    <= held_humidity_next;
        held_battery     <= held_battery_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && fb_we) begin
      field_bytes[idx[2:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      found             <= match_found_next;
      format            <= held_format_next;
      temperature_centi <= held_temperature_next;
      humidity_centi    <= held_humidity_next;
      battery           <= held_battery_next;
    end
  end

endmodule

[rtl/btad_div1000.sv]
// Registered divide-by-1000 stage built on a reciprocal multiply.
`timescale 1ns / 1ps
module btad_div1000
  import btad_pkg::*;
(
  input  logic               clk,
  input  logic [VALUE_W-1:0] value,
  output logic [QUOT_W-1:0]  quotient
);

  logic [VALUE_W+RECIP_W-1:0] product;

  assign product = {{RECIP_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP_1000};

  always_ff @(posedge clk) begin
    quotient <= product[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  end

endmodule

[rtl/btad_checker.sv]
// Port-level checker for the sensor decoder and its bind to the top level.
`timescale 1ns / 1ps
module btad_checker
  import btad_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [1:0]  format,
  input logic [15:0] temperature_centi,
  input logic [15:0] humidity_centi,
  input logic [7:0]  battery
);

  // A byte that is offered and not taken stays offered unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
    else $error("input changed while stalled");

  // A result that is not taken holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(format) &&
      $stable(temperature_centi) && $stable(humidity_centi) && $stable(battery))
    else $error("result changed while stalled");

  // A miss reports all fields as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> format == FMT_NONE && temperature_centi == 16'd0 &&
      humidity_centi == 16'd0 && battery == 8'd0)
    else $error("miss with nonzero fields");

  // A hit always names one of the two layouts.
  a_hit_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> format == FMT_EIGHT || format == FMT_NINE)
    else $error("hit without a layout");

  // A result appears only after the transaction that carried the last byte.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(in_valid && in_ready && last_byte))
    else $error("result without a last byte");

endmodule

bind ble_thermo_advert_decoder_core btad_checker u_btad_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .data_byte         (data_byte),
  .last_byte         (last_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .found             (found),
  .format            (format),
  .temperature_centi (temperature_centi),
  .humidity_centi    (humidity_centi),
  .battery           (battery)
);

[test/tb.sv]
// Self-checking testbench for the advertising payload sensor decoder core.
`timescale 1ns / 1ps
module tb;
  import btad_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_BYTES = 1700;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef enum logic [1:0] {AT_LENGTH, AT_TYPE, AT_DATA} walk_phase_t;

  typedef struct packed {
    logic        found;
    fmt_t        format;
    logic [15:0] temperature;
    logic [15:0] humidity;
    byte_t       battery;
  } sensor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [1:0] format;
  logic signed [15:0] temperature_centi;
  logic [15:0] humidity_centi;
  logic [7:0] battery;

  walk_phase_t walk_phase;
  byte_t remaining;
  byte_t data_count;
  logic vendor_type;
  byte_t field_buf [9];
  sensor_report_t held_report;
  sensor_report_t expected_reports [$];

  byte_t advert [$];
  logic tx_idle_enable = 1'b0;
  logic rx_idle_enable = 1'b0;
  int hold_ticket = 0;
  int hold_served = 0;
  int rx_wait_left = 0;
  int quiet_cycles = 0;

  int bytes_sent = 0;
  int adverts_sent = 0;
  int reports_checked = 0;
  int eight_byte_seen = 0;
  int nine_byte_seen = 0;
  int input_stall_cycles = 0;
  int mismatch_count = 0;

  sensor_report_t got_report;
  sensor_report_t want_report;
  logic report_bad;

  ble_thermo_advert_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .format(format),
    .temperature_centi(temperature_centi),
    .humidity_centi(humidity_centi),
    .battery(battery)
  );

  always #5 clk = ~clk;

  function automatic void reset_walker();
    walk_phase = AT_LENGTH;
    remaining = '0;
    data_count = '0;
    vendor_type = 1'b0;
    held_report = '0;
    foreach (field_buf[i]) field_buf[i] = '0;
  endfunction

  function automatic void decode_sensor_field();
    logic [23:0] raw;
    logic [18:0] magnitude;
    logic [15:0] centi;
    if (!vendor_type || field_buf[0] != MARK_A || field_buf[1] != MARK_B) return;
    if (data_count == 8'd8) begin
      raw = {field_buf[3], field_buf[4], field_buf[5]};
      magnitude = raw[18:0];
      centi = 16'(magnitude / 19'd1000) * 16'd10;
      held_report.temperature = raw[23] ? 16'(-centi) : centi;
      held_report.humidity = 16'(magnitude % 19'd1000) * 16'd10;
      held_report.battery = field_buf[6];
      held_report.format = FMT_EIGHT;
      held_report.found = 1'b1;
    end else if (data_count == 8'd9) begin
      held_report.temperature = {field_buf[4], field_buf[3]};
      held_report.humidity = {field_buf[6], field_buf[5]};
      held_report.battery = field_buf[7];
      held_report.format = FMT_NINE;
      held_report.found = 1'b1;
    end
  endfunction

  // Advances the structure walk by one payload byte and queues the report on the last byte.
  function automatic void track_byte(input byte_t value, input logic is_last);
    byte_t slot;
    if (!held_report.found) begin
      case (walk_phase)
        AT_LENGTH: begin
          if (value != 8'd0) begin
            data_count = value - 8'd1;
            walk_phase = AT_TYPE;
          end
        end
        AT_TYPE: begin
          vendor_type = (value == VENDOR_TYPE);
          if (data_count == 8'd0) begin
            walk_phase = AT_LENGTH;
          end else begin
            remaining = data_count;
            walk_phase = AT_DATA;
          end
        end
        default: begin
          slot = data_count - remaining;
          if (slot < 8'd9) field_buf[slot] = value;
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            decode_sensor_field();
            walk_phase = AT_LENGTH;
          end
        end
      endcase
    end
    if (is_last) begin
      expected_reports.push_back(held_report);
      reset_walker();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_field(input byte_t len, input byte_t kind, input logic marked);
    advert.push_back(len);
    if (len == 8'd0) return;
    advert.push_back(kind);
    for (int i = 0; i + 1 < len; i++) begin
      if (marked && i == 0) advert.push_back(MARK_A);
      else if (marked && i == 1) advert.push_back(MARK_B);
      else advert.push_back(byte_t'($urandom));
    end
  endfunction

  function automatic void add_sensor8(input logic [23:0] raw, input byte_t level);
    advert.push_back(8'd9);
    advert.push_back(VENDOR_TYPE);
    advert.push_back(MARK_A);
    advert.push_back(MARK_B);
    advert.push_back(byte_t'($urandom));
    advert.push_back(raw[23:16]);
    advert.push_back(raw[15:8]);
    advert.push_back(raw[7:0]);
    advert.push_back(level);
    advert.push_back(byte_t'($urandom));
  endfunction

  function automatic void add_sensor9(input logic [15:0] temp, input logic [15:0] hum,
                                     input byte_t level);
    advert.push_back(8'd10);
    advert.push_back(VENDOR_TYPE);
    advert.push_back(MARK_A);
    advert.push_back(MARK_B);
    advert.push_back(byte_t'($urandom));
    advert.push_back(temp[7:0]);
    advert.push_back(temp[15:8]);
    advert.push_back(hum[7:0]);
    advert.push_back(hum[15:8]);
    advert.push_back(level);
    advert.push_back(byte_t'($urandom));
  endfunction

  // Flips one bit in the type byte or one of the two marker bytes of the newest field.
  function automatic void spoil_last_field(input int span);
    int at;
    at = advert.size() - span + $urandom_range(1, 3);
    advert[at] = advert[at] ^ byte_t'(1 << $urandom_range(0, 7));
  endfunction

  function automatic void cut_advert(input int keep);
    while (advert.size() > keep) advert.delete(advert.size() - 1);
  endfunction

  task automatic pause_input(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_byte(input byte_t value, input logic is_last);
    in_valid <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    track_byte(value, is_last);
    bytes_sent++;
    if (tx_idle_enable && $urandom_range(0, 3) == 0) pause_input(pick_gap());
  endtask

  task automatic send_advert();
    int count;
    count = advert.size();
    for (int i = 0; i < count; i++) send_byte(advert[i], i == count - 1);
    advert.delete();
    adverts_sent++;
  endtask

  task automatic wait_reports();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed_layouts();
    tx_idle_enable = 1'b0;
    rx_idle_enable = 1'b0;
    // A lone zero length byte that also ends the advertisement.
    advert.push_back(8'h00);
    send_advert();
    // Eight-byte field with sign and all magnitude bits set, completed by the last byte.
    add_sensor8(24'hFFFFFF, 8'hFF);
    send_advert();
    // Zero length and length one skipped, nine-byte field decoded, later match ignored.
    advert.push_back(8'h00);
    add_field(8'd1, 8'h16, 1'b0);
    add_sensor9(16'h8000, 16'hFFFF, 8'h00);
    add_sensor8(24'h07A11F, 8'h55);
    send_advert();
    // Other type, mangled type or marker, data lengths of 7 and 10, then a field cut off in its data.
    add_field(8'd9, 8'h16, 1'b1);
    add_sensor8(24'h000000, 8'h12);
    spoil_last_field(10);
    add_field(8'd8, VENDOR_TYPE, 1'b1);
    add_field(8'd11, VENDOR_TYPE, 1'b1);
    add_sensor8(24'h000000, 8'h00);
    cut_advert(advert.size() - 3);
    send_advert();
    // Cut off on the type byte, then on a length byte.
    advert.push_back(8'h05);
    advert.push_back(VENDOR_TYPE);
    send_advert();
    advert.push_back(8'h05);
    send_advert();
    // Zero eight-byte field and positive nine-byte extreme, each followed by a trailing zero length byte.
    add_sensor8(24'h000000, 8'h00);
    advert.push_back(8'h00);
    send_advert();
    add_sensor9(16'h7FFF, 16'h0000, 8'h64);
    advert.push_back(8'h00);
    send_advert();
    pause_input(1);
    wait_reports();
  endtask

  task automatic test_output_holdoff();
    tx_idle_enable = 1'b0;
    rx_idle_enable = 1'b0;
    hold_ticket++;
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) add_sensor9(16'($urandom), 16'($urandom), byte_t'($urandom));
      else advert.push_back(8'h00);
      send_advert();
    end
    pause_input(1);
    wait_reports();
  endtask

  task automatic build_random_advert();
    int fields;
    int pick;
    fields = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) advert.push_back(byte_t'($urandom));
      return;
    end
    repeat (fields) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: add_sensor8(24'($urandom), byte_t'($urandom));
        3, 4: add_sensor9(16'($urandom), 16'($urandom), byte_t'($urandom));
        5: advert.push_back(8'h00);
        6: add_field(8'd1, byte_t'($urandom), 1'b0);
        7: add_field(byte_t'($urandom_range(3, 12)), VENDOR_TYPE, 1'b1);
        8: add_field(byte_t'($urandom_range(2, 31)), byte_t'($urandom),
                     1'($urandom_range(0, 1)));
        default: begin
          add_sensor8(24'($urandom), byte_t'($urandom));
          spoil_last_field(10);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) cut_advert($urandom_range(1, advert.size()));
  endtask

  task automatic test_random_adverts();
    int start_bytes;
    int mode;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (adverts_sent % 8 == 0) begin
        mode = $urandom_range(0, 3);
        tx_idle_enable = mode[0];
        rx_idle_enable = mode[1];
      end
      build_random_advert();
      send_advert();
    end
    pause_input(1);
    wait_reports();
  endtask

  always @(posedge clk) begin
    if (rx_wait_left != 0) begin
      rx_wait_left = rx_wait_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      rx_wait_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_enable && $urandom_range(0, 4) == 0) begin
      rx_wait_left = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_report = '{found, format, temperature_centi, humidity_centi, battery};
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("Unexpected report at %0t: found=%0b format=%0d temp=%0d hum=%0d batt=%0d",
                   $realtime, got_report.found, got_report.format,
                   $signed(got_report.temperature), got_report.humidity, got_report.battery);
      end else begin
        want_report = expected_reports.pop_front();
        report_bad = (got_report.found !== want_report.found) ||
                     (got_report.format !== want_report.format) ||
                     (got_report.temperature !== want_report.temperature) ||
                     (got_report.humidity !== want_report.humidity) ||
                     (got_report.battery !== want_report.battery);
        if (report_bad) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("Report %0d mismatch at %0t", reports_checked, $realtime);
            $display("  expected found=%0b format=%0d temp=%0d hum=%0d batt=%0d",
                     want_report.found, want_report.format, $signed(want_report.temperature),
                     want_report.humidity, want_report.battery);
            $display("  actual   found=%0b format=%0d temp=%0d hum=%0d batt=%0d",
                     got_report.found, got_report.format, $signed(got_report.temperature),
                     got_report.humidity, got_report.battery);
          end
        end
      end
      reports_checked++;
      if (got_report.format == FMT_EIGHT) eight_byte_seen++;
      if (got_report.format == FMT_NINE) nine_byte_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) input_stall_cycles++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d reports outstanding.",
                 quiet_cycles, expected_reports.size());
        $display("[ble_thermo_advert_decoder_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    reset_walker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_layouts();
    test_output_holdoff();
    test_random_adverts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d payload bytes in %0d advertisements and %0d reports.",
             bytes_sent, adverts_sent, reports_checked);
    $display("Decoded %0d eight-byte and %0d nine-byte fields; input stalled %0d cycles.",
             eight_byte_seen, nine_byte_seen, input_stall_cycles);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("[ble_thermo_advert_decoder_core] OK");
    end else begin
      $display("[ble_thermo_advert_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

[ble_thermo_advert_decoder_core.f]
rtl/btad_pkg.sv
rtl/btad_div1000.sv
rtl/ble_thermo_advert_decoder_core.sv
rtl/btad_checker.sv
test/tb.sv
